// File: src/blfd_pkg.sv
// Package for the bounded list with find and delete.
// Holds request codes, stream field widths and the wave struct passed along the cell chain.
// No dependencies.
package blfd_pkg;

  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned ITEM_KEY_W    = 32;
  localparam int unsigned MATCH_INDEX_W = 6;
  localparam int unsigned ENTRY_COUNT_W = 7;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef struct packed {
    logic tok;
    logic found;
  } wave_t;

endpackage

// File: src/blfd_cell.sv
// One list slot: holds a key, compares it as the search wave passes and
// takes its neighbor's key during a delete. Depends on blfd_pkg.
module blfd_cell #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  blfd_pkg::wave_t      wave_i,
  input  logic [IDX_W-1:0]     pos_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic                 del_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic                 wr_en_i,
  input  logic [KEY_WIDTH-1:0] wr_key_i,
  input  logic [KEY_WIDTH-1:0] next_entry_i,
  output logic [KEY_WIDTH-1:0] entry_o,
  output blfd_pkg::wave_t      wave_o,
  output logic [IDX_W-1:0]     pos_o
);

  logic [KEY_WIDTH-1:0] entry_q;
  blfd_pkg::wave_t      wave_q, wave_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 live, hit;

  assign live = CNT_W'(IDX) < count_i;
  assign hit  = wave_i.tok & ~wave_i.found & live & (entry_q == key_i);

  always_comb begin
    wave_d.tok   = wave_i.tok;
    wave_d.found = wave_i.found | hit;
    pos_d        = hit ? IDX_W'(IDX) : pos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  // take an appended key, or shift down while the wave sits in the next cell after a match
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (wr_en_i && (count_i == CNT_W'(IDX))) begin
      entry_q <= wr_key_i;
    end else if (wave_q.tok && wave_q.found && del_i) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign wave_o  = wave_q;
  assign pos_o   = pos_q;

endmodule

// File: src/bounded_list_find_delete.sv
// Top level of the bounded ordered key list: request control and a chain of slot cells.
// Depends on blfd_pkg and blfd_cell.
//
//  channel  | dir | tdata fields (lsb first)                        | width
//  s_axis   | in  | opcode[1:0], item_key[33:2], zero pad             | 40
//  m_axis   | out | success[0], match_index[6:1], entry_count[13:7]   | 16
//
// Append and the unused opcode go straight from the idle state to the result register.
// Find and delete send a wave down the cell chain, one cell a cycle.
// Reset clears the count and control registers; slot contents stay undefined until appended.
// A new request is taken only once the previous result has been taken.
module bounded_list_find_delete #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // opcode, item_key
  input  logic [blfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // success, match_index, entry_count
  output logic [blfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q;
  logic                 start_q;
  logic                 del_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     count_q;
  logic                 m_valid_q;
  logic                 success_q;
  logic [IDX_W-1:0]     res_idx_q;

  logic                 accept;
  blfd_pkg::op_e        op;
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] in_key;
  logic                 full;
  logic                 wr_en;
  logic                 finish;
  logic [31:0]          idx_ext;
  logic [31:0]          cnt_ext;

  blfd_pkg::wave_t      wave_w  [CAPACITY+1];
  logic [IDX_W-1:0]     pos_w   [CAPACITY+1];
  logic [KEY_WIDTH-1:0] entry_w [CAPACITY];

  assign op      = blfd_pkg::op_e'(s_axis_tdata_i[blfd_pkg::OPCODE_W-1:0]);
  assign key_ext = 64'(s_axis_tdata_i[blfd_pkg::OPCODE_W +: blfd_pkg::ITEM_KEY_W]);
  assign in_key  = key_ext[KEY_WIDTH-1:0];
  assign full    = count_q >= CNT_W'(CAPACITY);

  assign s_axis_tready_o = (state_q == ST_IDLE) && !m_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = accept && (op == blfd_pkg::OP_APPEND) && !full;
  assign finish          = (state_q == ST_SCAN) && wave_w[CAPACITY].tok;

  assign wave_w[0] = '{tok: start_q, found: 1'b0};
  assign pos_w[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    blfd_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wave_i       (wave_w[i]),
      .pos_i        (pos_w[i]),
      .key_i        (key_q),
      .del_i        (del_q),
      .count_i      (count_q),
      .wr_en_i      (wr_en),
      .wr_key_i     (in_key),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[i]),
      .wave_o       (wave_w[i+1]),
      .pos_o        (pos_w[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      del_q     <= 1'b0;
      key_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      success_q <= 1'b0;
      res_idx_q <= '0;
    end else begin
      start_q <= accept && ((op == blfd_pkg::OP_FIND) || (op == blfd_pkg::OP_DELETE));
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              blfd_pkg::OP_APPEND: begin
                m_valid_q <= 1'b1;
                success_q <= !full;
                res_idx_q <= full ? '0 : IDX_W'(count_q);
                if (!full) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              blfd_pkg::OP_FIND,
              blfd_pkg::OP_DELETE: begin
                key_q   <= in_key;
                del_q   <= (op == blfd_pkg::OP_DELETE);
                state_q <= ST_SCAN;
              end
              default: begin
                m_valid_q <= 1'b1;
                success_q <= 1'b0;
                res_idx_q <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (finish) begin
            m_valid_q <= 1'b1;
            success_q <= wave_w[CAPACITY].found;
            res_idx_q <= wave_w[CAPACITY].found ? pos_w[CAPACITY] : '0;
            if (del_q && wave_w[CAPACITY].found) begin
              count_q <= count_q - CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idx_ext = 32'(res_idx_q);
  assign cnt_ext = 32'(count_q);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            cnt_ext[blfd_pkg::ENTRY_COUNT_W-1:0],
                            idx_ext[blfd_pkg::MATCH_INDEX_W-1:0],
                            success_q};

endmodule

// File: src/blfd_checker.sv
// Port-level checks for bounded_list_find_delete, bound to the top level.
// Depends on blfd_pkg for stream widths.
module blfd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [blfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [blfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i |-> !$isunknown(s_axis_tdata_i))
    else $error("request data unknown while valid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_fail_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[6:1] == 6'd0)
    else $error("failed request reports nonzero index");

  a_one_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request taken while a result is pending");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken back to back");

endmodule

bind bounded_list_find_delete blfd_checker u_blfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: verif/bounded_list_find_delete_tb.sv
// Testbench for bounded_list_find_delete: drives append, find, delete and unused-opcode requests
// over the request stream and checks every result against a behavioral list model kept here.
// Depends on blfd_pkg and the block's RTL.
module bounded_list_find_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = 64;
  localparam logic [blfd_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                               success;
    logic [blfd_pkg::MATCH_INDEX_W-1:0] index;
    logic [blfd_pkg::ENTRY_COUNT_W-1:0] count;
  } list_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [blfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [blfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [blfd_pkg::ITEM_KEY_W-1:0] key_store [LIST_DEPTH];
  int unsigned                     list_len;
  list_result_t                    pending_results[$];

  int unsigned err_count;
  int unsigned result_count;
  int unsigned request_count;
  int unsigned full_rejects;
  int unsigned find_hits;
  int unsigned delete_hits;
  int unsigned unused_ops;
  int unsigned max_len_seen;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;

  bounded_list_find_delete #(
    .CAPACITY (LIST_DEPTH),
    .KEY_WIDTH(blfd_pkg::ITEM_KEY_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic list_result_t apply_request(logic [blfd_pkg::OPCODE_W-1:0] op,
                                                 logic [blfd_pkg::ITEM_KEY_W-1:0] key);
    list_result_t res;
    int           pos;
    res = '0;
    pos = -1;
    if (op == blfd_pkg::OP_FIND || op == blfd_pkg::OP_DELETE) begin
      for (int i = 0; i < int'(list_len); i++) begin
        if (pos < 0 && key_store[i] == key) pos = i;
      end
    end
    case (op)
      blfd_pkg::OP_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          key_store[list_len] = key;
          res.index = list_len[blfd_pkg::MATCH_INDEX_W-1:0];
          res.success = 1'b1;
          list_len++;
        end else begin
          full_rejects++;
        end
      end
      blfd_pkg::OP_FIND: begin
        if (pos >= 0) begin
          res.success = 1'b1;
          res.index = pos[blfd_pkg::MATCH_INDEX_W-1:0];
          find_hits++;
        end
      end
      blfd_pkg::OP_DELETE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < int'(list_len); i++) key_store[i] = key_store[i + 1];
          list_len--;
          res.success = 1'b1;
          res.index = pos[blfd_pkg::MATCH_INDEX_W-1:0];
          delete_hits++;
        end
      end
      default: begin
        unused_ops++;
      end
    endcase
    if (list_len > max_len_seen) max_len_seen = list_len;
    res.count = list_len[blfd_pkg::ENTRY_COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH result %0d %s: got %0d, expected %0d",
             $time, result_count, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.success = m_axis_tdata[0];
      got.index   = m_axis_tdata[6:1];
      got.count   = m_axis_tdata[13:7];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, count field", got.count, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.success !== want.success) report_mismatch("success", got.success, want.success);
        if (got.index !== want.index) report_mismatch("match_index", got.index, want.index);
        if (got.count !== want.count) report_mismatch("entry_count", got.count, want.count);
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic send_request(logic [blfd_pkg::OPCODE_W-1:0] op,
                              logic [blfd_pkg::ITEM_KEY_W-1:0] key);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(blfd_pkg::IN_TDATA_W - blfd_pkg::OPCODE_W - blfd_pkg::ITEM_KEY_W){1'b0}},
                      key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(op, key));
    request_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned sink_pct);
    wait_drained();
    send_idle_pct  = send_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic test_directed();
    send_request(blfd_pkg::OP_FIND, 32'h0000_0000);
    send_request(blfd_pkg::OP_DELETE, 32'hFFFF_FFFF);
    send_request(blfd_pkg::OP_APPEND, 32'h0000_0000);
    send_request(blfd_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_request(blfd_pkg::OP_APPEND, 32'h5A5A_5A5A);
    send_request(blfd_pkg::OP_APPEND, 32'h0000_0000);
    send_request(blfd_pkg::OP_APPEND, 32'hA5A5_A5A5);
    send_request(blfd_pkg::OP_FIND, 32'h0000_0000);
    send_request(blfd_pkg::OP_FIND, 32'hFFFF_FFFF);
    send_request(blfd_pkg::OP_FIND, 32'hA5A5_A5A5);
    send_request(blfd_pkg::OP_FIND, 32'h1234_5678);
    send_request(blfd_pkg::OP_DELETE, 32'h8765_4321);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'h0000_0000);
    send_request(blfd_pkg::OP_DELETE, 32'h0000_0000);
    send_request(blfd_pkg::OP_FIND, 32'h0000_0000);
    send_request(blfd_pkg::OP_DELETE, 32'hA5A5_A5A5);
    send_request(blfd_pkg::OP_DELETE, 32'hFFFF_FFFF);
    send_request(blfd_pkg::OP_DELETE, 32'h0000_0000);
    send_request(blfd_pkg::OP_DELETE, 32'h5A5A_5A5A);
    send_request(blfd_pkg::OP_FIND, 32'h5A5A_5A5A);
  endtask

  task automatic test_full_list();
    logic [blfd_pkg::ITEM_KEY_W-1:0] tail_key;
    while (list_len < LIST_DEPTH) send_request(blfd_pkg::OP_APPEND, $urandom());
    tail_key = key_store[LIST_DEPTH - 1];
    send_request(blfd_pkg::OP_APPEND, 32'hDEAD_BEEF);
    send_request(OP_UNUSED, 32'hDEAD_BEEF);
    send_request(blfd_pkg::OP_FIND, tail_key);
    send_request(blfd_pkg::OP_DELETE, tail_key);
    send_request(blfd_pkg::OP_DELETE, key_store[0]);
    send_request(blfd_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_request(blfd_pkg::OP_APPEND, 32'h0000_0000);
    send_request(blfd_pkg::OP_APPEND, 32'h1111_1111);
    while (list_len > 0) send_request(blfd_pkg::OP_DELETE, key_store[0]);
    send_request(blfd_pkg::OP_FIND, tail_key);
  endtask

  task automatic test_random_phase(int unsigned n_items);
    logic [blfd_pkg::ITEM_KEY_W-1:0] key_pool [8];
    logic [blfd_pkg::ITEM_KEY_W-1:0] key;
    int unsigned                     fill_target;
    int unsigned                     sel;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    fill_target = 0;
    for (int n = 0; n < int'(n_items); n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: fill_target = 0;
          1: fill_target = 8;
          2: fill_target = 32;
          default: fill_target = LIST_DEPTH + 4;
        endcase
      end
      key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 7)] : $urandom();
      if (list_len > 0 && $urandom_range(0, 3) == 0) key = key_store[$urandom_range(0, list_len - 1)];
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        send_request(OP_UNUSED, key);
      end else if (sel < 24) begin
        send_request(blfd_pkg::OP_FIND, key);
      end else if (list_len < fill_target) begin
        send_request((sel < 80) ? blfd_pkg::OP_APPEND : blfd_pkg::OP_DELETE, key);
      end else begin
        send_request((sel < 40) ? blfd_pkg::OP_APPEND : blfd_pkg::OP_DELETE, key);
      end
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    list_len = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_idling(20, 20);
    test_full_list();

    set_idling(0, 0);
    test_random_phase(100);
    set_idling(56, 0);
    test_random_phase(100);
    set_idling(0, 56);
    test_random_phase(100);
    set_idling(36, 36);
    test_random_phase(100);

    wait_drained();
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    $display("Covered %0d requests: %0d full-list rejects, %0d find hits, %0d deletes,",
             request_count, full_rejects, find_hits, delete_hits);
    $display("%0d unused opcodes, peak list length %0d, %0d results checked.",
             unused_ops, max_len_seen, result_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
